// File: hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds in the same cycle, disabled while reset is asserted.
`define PIT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property whose consequence is checked in the cycle after the antecedent.
`define PIT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pit_pkg.sv
package pit_pkg;

    // Number of channel slots the decode logic is built for.
    localparam int MAX_CHANNELS = 3;

    // Request type codes.
    localparam logic [2:0] REQ_READ  = 3'd0;
    localparam logic [2:0] REQ_WRITE = 3'd1;
    localparam logic [2:0] REQ_FETCH = 3'd2;
    localparam logic [2:0] REQ_TICK  = 3'd3;
    localparam logic [2:0] REQ_GATE  = 3'd4;

    // Status codes.
    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_UNSUPPORTED = 2'd1;
    localparam logic [1:0] STAT_NOT_PROG    = 2'd2;
    localparam logic [1:0] STAT_INVALID     = 2'd3;

    // Access mode codes of the control word.
    localparam logic [1:0] AM_LATCH = 2'd0;
    localparam logic [1:0] AM_LOW   = 2'd1;
    localparam logic [1:0] AM_HIGH  = 2'd2;
    localparam logic [1:0] AM_BOTH  = 2'd3;

    // Counting modes with special handling.
    localparam logic [2:0] MODE_ONE_SHOT = 3'd0;
    localparam logic [2:0] MODE_RATE     = 3'd2;
    localparam logic [2:0] MODE_SQUARE   = 3'd3;
    localparam logic [2:0] MODE_LAST     = 3'd5;

    // Port offset of the control register and the bus access size.
    localparam logic [1:0] CTRL_PORT = 2'd3;
    localparam logic [3:0] BYTE_SIZE = 4'd1;

    // A load of zero counts the full 16-bit range.
    localparam logic [16:0] FULL_COUNT = 17'h10000;

    localparam logic [15:0] IO_BASE_RESET = 16'd64;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] address;
        logic [3:0]  access_size;
        logic [7:0]  write_data;
        logic [1:0]  gate_channel;
        logic        gate_level;
    } pit_req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] status;
        logic [2:0] out_levels;
        logic [2:0] pulse_mask;
    } pit_rsp_t;

    // Command from the decoder to one channel; at most one strobe except tick.
    typedef struct packed {
        logic       rd;
        logic       wr;
        logic       ctrl;
        logic       tick;
        logic       gate;
        logic [7:0] data;
        logic       gate_level;
    } pit_chan_cmd_t;

    // Per-channel reply; level is the output after this step.
    typedef struct packed {
        logic [7:0] rdata;
        logic [1:0] status;
        logic       pulse;
        logic       level;
    } pit_chan_rsp_t;

endpackage

// File: hdl/pit_if.sv
// Request channel.
interface pit_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [15:0] address;
    logic [3:0]  access_size;
    logic [7:0]  write_data;
    logic [1:0]  gate_channel;
    logic        gate_level;

    modport source (output valid, output req_type, output address, output access_size,
                    output write_data, output gate_channel, output gate_level,
                    input ready);
    modport sink (input valid, input req_type, input address, input access_size,
                  input write_data, input gate_channel, input gate_level,
                  output ready);
endinterface

// Result channel.
interface pit_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [1:0] status;
    logic [2:0] out_levels;
    logic [2:0] pulse_mask;

    modport source (output valid, output read_data, output status, output out_levels,
                    output pulse_mask, input ready);
    modport sink (input valid, input read_data, input status, input out_levels,
                  input pulse_mask, output ready);
endinterface

// Configuration write channel for the base address.
interface pit_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/pit_chan.sv
module pit_chan (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pit_pkg::pit_chan_cmd_t cmd,
    output pit_pkg::pit_chan_rsp_t rsp
);

    logic [16:0] reload_reg, reload_next;
    logic [16:0] count_reg, count_next;
    logic [2:0]  mode_reg, mode_next;
    logic [1:0]  am_reg, am_next;
    logic        hbe_reg, hbe_next;
    logic        toggle_reg, toggle_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] latched_reg, latched_next;
    logic [1:0]  left_reg, left_next;
    logic        low_first_reg, low_first_next;
    logic        gate_reg, gate_next;
    logic        out_reg, out_next;

    logic        do_start;
    logic [15:0] load_val;
    logic [16:0] start_val;
    logic [2:0]  mode_sel;
    logic [1:0]  rw_sel;

    // Next state of the channel for the one command of this step.
    always_comb
    begin
        reload_next    = reload_reg;
        count_next     = count_reg;
        mode_next      = mode_reg;
        am_next        = am_reg;
        hbe_next       = hbe_reg;
        toggle_next    = toggle_reg;
        held_next      = held_reg;
        latched_next   = latched_reg;
        left_next      = left_reg;
        low_first_next = low_first_reg;
        gate_next      = gate_reg;
        out_next       = out_reg;
        rsp            = '0;
        do_start       = 1'b0;
        load_val       = 16'd0;
        rw_sel         = cmd.data[5:4];
        mode_sel       = cmd.data[3:1];
        if (mode_sel > pit_pkg::MODE_LAST)
        begin
            mode_sel = {1'b0, mode_sel[1:0]};
        end

        // Count load through the selected access mode.
        if (cmd.wr)
        begin
            case (am_reg)
                pit_pkg::AM_LOW:
                begin
                    do_start = 1'b1;
                    load_val = {8'd0, cmd.data};
                end
                pit_pkg::AM_HIGH:
                begin
                    do_start = 1'b1;
                    load_val = {cmd.data, 8'd0};
                end
                pit_pkg::AM_BOTH:
                begin
                    if (hbe_reg)
                    begin
                        do_start = 1'b1;
                        load_val = {cmd.data, held_reg};
                        hbe_next = 1'b0;
                    end
                    else
                    begin
                        held_next = cmd.data;
                        hbe_next  = 1'b1;
                    end
                end
                default:
                begin
                    rsp.status = pit_pkg::STAT_NOT_PROG;
                end
            endcase
        end

        // Starting a count reloads both counters and sets the output high, or low in one-shot mode.
        start_val = (load_val == 16'd0) ? pit_pkg::FULL_COUNT : {1'b0, load_val};
        if (do_start)
        begin
            reload_next = start_val;
            count_next  = start_val;
            out_next    = (mode_reg != pit_pkg::MODE_ONE_SHOT);
        end

        // Byte read of the latched or live count.
        if (cmd.rd)
        begin
            if (left_reg != 2'd0)
            begin
                left_next = left_reg - 2'd1;
                case (am_reg)
                    pit_pkg::AM_HIGH:
                    begin
                        rsp.rdata = latched_reg[15:8];
                    end
                    pit_pkg::AM_BOTH:
                    begin
                        rsp.rdata      = low_first_reg ? latched_reg[7:0] : latched_reg[15:8];
                        low_first_next = ~low_first_reg;
                    end
                    default:
                    begin
                        rsp.rdata = latched_reg[7:0];
                    end
                endcase
            end
            else
            begin
                case (am_reg)
                    pit_pkg::AM_HIGH:
                    begin
                        rsp.rdata = count_reg[15:8];
                    end
                    pit_pkg::AM_BOTH:
                    begin
                        toggle_next = ~toggle_reg;
                        rsp.rdata   = toggle_reg ? count_reg[15:8] : count_reg[7:0];
                    end
                    default:
                    begin
                        rsp.rdata = count_reg[7:0];
                    end
                endcase
            end
        end

        // Control word: latch command or access and mode setup.
        if (cmd.ctrl)
        begin
            if (rw_sel == pit_pkg::AM_LATCH)
            begin
                if (left_reg == 2'd0)
                begin
                    latched_next   = count_reg[15:0];
                    left_next      = (am_reg == pit_pkg::AM_BOTH) ? 2'd2 : 2'd1;
                    low_first_next = 1'b1;
                end
            end
            else
            begin
                am_next   = rw_sel;
                mode_next = mode_sel;
                if (cmd.data[0] || !(mode_sel inside {pit_pkg::MODE_ONE_SHOT,
                                                      pit_pkg::MODE_RATE,
                                                      pit_pkg::MODE_SQUARE}))
                begin
                    rsp.status = pit_pkg::STAT_UNSUPPORTED;
                end
                else
                begin
                    hbe_next    = 1'b0;
                    toggle_next = 1'b0;
                    left_next   = 2'd0;
                end
            end
        end

        // One clock tick while the gate is high and the count is nonzero: decrement, and handle expiry per mode.
        if (cmd.tick && gate_reg && (count_reg != 17'd0))
        begin
            if (count_reg == 17'd1)
            begin
                if (mode_reg == pit_pkg::MODE_ONE_SHOT)
                begin
                    count_next = 17'd0;
                    out_next   = 1'b1;
                end
                else
                begin
                    count_next = reload_reg;
                    if (mode_reg == pit_pkg::MODE_SQUARE)
                    begin
                        out_next = ~out_reg;
                    end
                    else
                    begin
                        rsp.pulse = out_reg;
                        out_next  = 1'b1;
                    end
                end
            end
            else
            begin
                count_next = count_reg - 17'd1;
            end
        end

        if (cmd.gate)
        begin
            gate_next = cmd.gate_level;
        end

        rsp.level = out_next;
    end

    // Channel state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg    <= '0;
            count_reg     <= '0;
            mode_reg      <= '0;
            am_reg        <= pit_pkg::AM_LATCH;
            hbe_reg       <= 1'b0;
            toggle_reg    <= 1'b0;
            held_reg      <= '0;
            latched_reg   <= '0;
            left_reg      <= '0;
            low_first_reg <= 1'b0;
            gate_reg      <= 1'b1;
            out_reg       <= 1'b1;
        end
        else
        begin
            reload_reg    <= reload_next;
            count_reg     <= count_next;
            mode_reg      <= mode_next;
            am_reg        <= am_next;
            hbe_reg       <= hbe_next;
            toggle_reg    <= toggle_next;
            held_reg      <= held_next;
            latched_reg   <= latched_next;
            left_reg      <= left_next;
            low_first_reg <= low_first_next;
            gate_reg      <= gate_next;
            out_reg       <= out_next;
        end
    end

endmodule

// File: hdl/interval_timer_three_channel_unit.sv
// Path: a request is registered in the input register, decoded, applied as one counter step in
// the channels, and its result is registered in the result register, which takes it while that
// register is free or draining.
// Throughput: one request per cycle while results are taken; a stalled result leaves the next
// request in the input register, and the input stops until the result transfers.
// Reset (rst_n low, asynchronous) clears all channels to unprogrammed and idle, gates on, outputs high, base 64.
module interval_timer_three_channel_unit #(
    parameter int CHANNEL_COUNT = 3
) (
    input logic        clk,
    input logic        rst_n,
    pit_req_if.sink    req,
    pit_rsp_if.source  rsp,
    pit_cfg_if.sink    cfg
);

    localparam logic [2:0] CH_LIMIT = 3'(CHANNEL_COUNT);

    logic              in_valid_reg;
    pit_pkg::pit_req_t in_item_reg;
    logic              out_valid_reg;
    pit_pkg::pit_rsp_t out_item_reg, out_item_next;
    logic [15:0]       io_base_reg;
    logic              fire;

    logic [15:0]       port;
    logic [1:0]        pch;
    logic [1:0]        cch;
    logic [1:0]        top_status;

    pit_pkg::pit_chan_cmd_t cmd [pit_pkg::MAX_CHANNELS];
    pit_pkg::pit_chan_rsp_t crsp [pit_pkg::MAX_CHANNELS];

    // Process the held request when the result register is free or draining.
    assign fire      = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || fire;
    assign cfg.ready = 1'b1;

    // Base address register, written through the configuration channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            io_base_reg <= pit_pkg::IO_BASE_RESET;
        end
        else if (cfg.valid)
        begin
            io_base_reg <= cfg.data;
        end
    end

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_item_reg.req_type     <= req.req_type;
            in_item_reg.address      <= req.address;
            in_item_reg.access_size  <= req.access_size;
            in_item_reg.write_data   <= req.write_data;
            in_item_reg.gate_channel <= req.gate_channel;
            in_item_reg.gate_level   <= req.gate_level;
        end
    end

    // Decode the request into per-channel commands.
    assign port = in_item_reg.address - io_base_reg;
    assign pch  = port[1:0];
    assign cch  = in_item_reg.write_data[7:6];

    always_comb
    begin
        for (int i = 0; i < pit_pkg::MAX_CHANNELS; i++)
        begin
            cmd[i]            = '0;
            cmd[i].data       = in_item_reg.write_data;
            cmd[i].gate_level = in_item_reg.gate_level;
        end
        top_status = pit_pkg::STAT_OK;
        if (fire)
        begin
            case (in_item_reg.req_type)
                pit_pkg::REQ_READ, pit_pkg::REQ_WRITE, pit_pkg::REQ_FETCH:
                begin
                    if (in_item_reg.access_size != pit_pkg::BYTE_SIZE ||
                        in_item_reg.req_type == pit_pkg::REQ_FETCH ||
                        port[15:2] != 14'd0)
                    begin
                        top_status = pit_pkg::STAT_UNSUPPORTED;
                    end
                    else if (in_item_reg.req_type == pit_pkg::REQ_READ)
                    begin
                        if ({1'b0, pch} >= CH_LIMIT)
                        begin
                            top_status = pit_pkg::STAT_UNSUPPORTED;
                        end
                        else
                        begin
                            cmd[pch].rd = 1'b1;
                        end
                    end
                    else if (pch == pit_pkg::CTRL_PORT)
                    begin
                        if ({1'b0, cch} >= CH_LIMIT)
                        begin
                            top_status = pit_pkg::STAT_UNSUPPORTED;
                        end
                        else
                        begin
                            cmd[cch].ctrl = 1'b1;
                        end
                    end
                    else if ({1'b0, pch} >= CH_LIMIT)
                    begin
                        top_status = pit_pkg::STAT_UNSUPPORTED;
                    end
                    else
                    begin
                        cmd[pch].wr = 1'b1;
                    end
                end
                pit_pkg::REQ_TICK:
                begin
                    for (int i = 0; i < pit_pkg::MAX_CHANNELS; i++)
                    begin
                        cmd[i].tick = 1'b1;
                    end
                end
                pit_pkg::REQ_GATE:
                begin
                    if ({1'b0, in_item_reg.gate_channel} >= CH_LIMIT)
                    begin
                        top_status = pit_pkg::STAT_INVALID;
                    end
                    else
                    begin
                        cmd[in_item_reg.gate_channel].gate = 1'b1;
                    end
                end
                default:
                begin
                    top_status = pit_pkg::STAT_UNSUPPORTED;
                end
            endcase
        end
    end

    // Channel slots; slots past the configured count read as idle and low.
    for (genvar g = 0; g < pit_pkg::MAX_CHANNELS; g++)
    begin : g_chan
        if (g < CHANNEL_COUNT)
        begin : g_used
            pit_chan u_chan (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cmd[g]),
                .rsp   (crsp[g])
            );
        end
        else
        begin : g_unused
            assign crsp[g] = '0;
        end
    end

    // Merge the channel replies into one result.
    always_comb
    begin
        out_item_next        = '0;
        out_item_next.status = top_status;
        for (int i = 0; i < pit_pkg::MAX_CHANNELS; i++)
        begin
            out_item_next.read_data     = out_item_next.read_data | crsp[i].rdata;
            out_item_next.status        = out_item_next.status | crsp[i].status;
            out_item_next.out_levels[i] = crsp[i].level;
            out_item_next.pulse_mask[i] = crsp[i].pulse;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = out_item_reg.read_data;
    assign rsp.status     = out_item_reg.status;
    assign rsp.out_levels = out_item_reg.out_levels;
    assign rsp.pulse_mask = out_item_reg.pulse_mask;

endmodule

// File: hdl/pit_checker.sv
`include "assert_macros.svh"

module pit_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] read_data,
    input logic [1:0] status,
    input logic [2:0] out_levels,
    input logic [2:0] pulse_mask
);

    logic [1:0] inflight_reg, inflight_next;

    // Count requests taken whose results have not yet been transferred out.
    always_comb
    begin
        inflight_next = inflight_reg;
        if (req_valid && req_ready && !(rsp_valid && rsp_ready))
        begin
            inflight_next = inflight_reg + 2'd1;
        end
        else if (!(req_valid && req_ready) && rsp_valid && rsp_ready)
        begin
            inflight_next = inflight_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 2'd0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A stalled result keeps its payload.
    `PIT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable({read_data, status, out_levels, pulse_mask}), "stalled result changed")

    // No result is shown without a request behind it, and at most two are held.
    `PIT_ASSERT_NOW(a_no_invent, clk, rst_n, rsp_valid, inflight_reg != 2'd0 && inflight_reg <= 2'd2, "result without pending request")

    // A pulse leaves the output high and comes from a clean tick.
    `PIT_ASSERT_NOW(a_pulse_level, clk, rst_n, rsp_valid && pulse_mask != 3'd0, (pulse_mask & ~out_levels) == 3'd0 && status == 2'd0 && read_data == 8'd0, "pulse with low output")

    // Read data only comes with an accepted access.
    `PIT_ASSERT_NOW(a_read_ok, clk, rst_n, rsp_valid && read_data != 8'd0, status == 2'd0 && pulse_mask == 3'd0, "read data on failed access")

endmodule

bind interval_timer_three_channel_unit pit_checker u_pit_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .read_data  (rsp.read_data),
    .status     (rsp.status),
    .out_levels (rsp.out_levels),
    .pulse_mask (rsp.pulse_mask)
);
